### hw/rtl/tql_pkg.sv
// Package for the tabular Q-learning engine: sizes, opcodes, register indexes,
// the command record passed from front end to back end, and fixed-point helpers.
// No dependencies.
package tql_pkg;

	localparam int NUM_STATES = 1024;
	localparam int NUM_ACTIONS = 8;
	localparam int STATE_W = 10;
	localparam int ACTION_W = 3;
	localparam int ENTRY_W = STATE_W + ACTION_W;
	localparam int VALUE_W = 32;
	localparam int FRAC_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SELECT = 2'd1,
		OP_TRAIN = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_DISCOUNT = 3'd1,
		REG_EXPLORE_RATE = 3'd2,
		REG_MINIMIZE_MODE = 3'd3,
		REG_TRAINING_ON = 3'd4
	} reg_index_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		opcode_t op;
		logic [STATE_W-1:0] scan_state;
		logic [ENTRY_W-1:0] entry;
		logic signed [VALUE_W-1:0] reward;
		logic is_terminal;
		logic signed [VALUE_W-1:0] table_value;
		logic explore;
		logic [15:0] pick_draw;
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] chosen_action;
		logic signed [VALUE_W-1:0] best_value;
		logic signed [VALUE_W-1:0] bellman_error;
		logic signed [VALUE_W-1:0] updated_value;
	} result_t;

	// Saturate a 34-bit signed sum to the value width.
	function automatic logic signed [VALUE_W-1:0] sat34(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		begin
			hi = 34'sh07FFFFFFF;
			lo = -34'sh080000000;
			if (v > hi) sat34 = 32'sh7FFFFFFF;
			else if (v < lo) sat34 = 32'sh80000000;
			else sat34 = v[VALUE_W-1:0];
		end
	endfunction

endpackage

### hw/rtl/tql_if.sv
// Valid/ready channel interfaces for the Q-learning engine.
// Depends on tql_pkg for payload widths.
interface tql_in_if import tql_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [STATE_W-1:0] state_index;
	logic [ACTION_W-1:0] action_index;
	logic [STATE_W-1:0] next_state_index;
	logic signed [VALUE_W-1:0] reward;
	logic is_terminal;
	logic signed [VALUE_W-1:0] table_value;
	logic [15:0] explore_draw;
	logic [15:0] pick_draw;
	modport source (output valid, opcode, state_index, action_index, next_state_index,
		reward, is_terminal, table_value, explore_draw, pick_draw, input ready);
	modport sink (input valid, opcode, state_index, action_index, next_state_index,
		reward, is_terminal, table_value, explore_draw, pick_draw, output ready);
endinterface

interface tql_out_if import tql_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACTION_W-1:0] chosen_action;
	logic signed [VALUE_W-1:0] best_value;
	logic signed [VALUE_W-1:0] bellman_error;
	logic signed [VALUE_W-1:0] updated_value;
	modport source (output valid, chosen_action, best_value, bellman_error,
		updated_value, input ready);
	modport sink (input valid, chosen_action, best_value, bellman_error,
		updated_value, output ready);
endinterface

interface tql_cfg_if import tql_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/tql_front.sv
// Front end: accepts input transactions, decodes them and decides exploration.
// Depends on tql_pkg and tql_if.
module tql_front import tql_pkg::*; (
	tql_in_if.sink in_ch,
	input logic [FRAC_W-1:0] explore_rate,
	input logic training_on,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);

	logic [FRAC_W-1:0] eps;
	logic [2*16-1:0] rand_prod;

	assign in_ch.ready = cmd_ready;
	assign cmd_valid = in_ch.valid;
	assign eps = (explore_rate > ONE_Q16) ? ONE_Q16 : explore_rate;
	assign rand_prod = in_ch.pick_draw * 16'(NUM_ACTIONS);

	// Classify the transaction; a train with training off becomes a no-op.
	always_comb begin
		cmd.op = opcode_t'(in_ch.opcode);
		if (cmd.op == OP_TRAIN && !training_on) cmd.op = OP_NONE;
		cmd.scan_state = (cmd.op == OP_TRAIN) ? in_ch.next_state_index : in_ch.state_index;
		cmd.entry = {in_ch.state_index, in_ch.action_index};
		cmd.reward = in_ch.reward;
		cmd.is_terminal = in_ch.is_terminal;
		cmd.table_value = in_ch.table_value;
		cmd.explore = (eps != '0) && ({1'b0, in_ch.explore_draw} <= eps);
		cmd.pick_draw = cmd.explore ? {rand_prod[ACTION_W+15:16], 13'd0} : in_ch.pick_draw;
	end

endmodule

### hw/rtl/tql_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on tql_pkg.
module tql_queue import tql_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input cmd_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output cmd_t rd_data
);

	cmd_t mem_q [QUEUE_DEPTH];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != 2'(QUEUE_DEPTH));
	assign rd_valid = (count_q != 2'd0);
	assign rd_data = mem_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	// Storage is written on push only.
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### hw/rtl/tql_back.sv
// Back end: writes loaded entries, scans one state's actions, does the Q update and writes back.
// Holds the Q table memory. Depends on tql_pkg and tql_if.
module tql_back import tql_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	input logic [FRAC_W-1:0] learning_rate,
	input logic [FRAC_W-1:0] discount,
	input logic minimize_mode,
	tql_out_if.source out_ch
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_TIE, S_OLD, S_MUL1, S_MUL2, S_MUL3, S_SUM, S_DONE
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic signed [VALUE_W-1:0] q_mem [NUM_STATES*NUM_ACTIONS];
	logic signed [VALUE_W-1:0] rd_data_q;
	logic [ENTRY_W-1:0] rd_addr;
	logic rd_en;
	logic [ACTION_W:0] scan_cnt_q;
	logic [ACTION_W-1:0] cur_act_q;
	logic signed [VALUE_W-1:0] best_q;
	logic [NUM_ACTIONS-1:0] tie_mask_q;
	logic [ACTION_W:0] tie_count_q;
	logic [ACTION_W-1:0] tie_pos;
	logic [ACTION_W-1:0] chosen_q;
	logic signed [VALUE_W-1:0] old_q;
	logic signed [VALUE_W-1:0] target_q;
	logic signed [VALUE_W-1:0] err_q;
	logic signed [VALUE_W-1:0] prod_a_q;
	logic signed [VALUE_W-1:0] prod_b_q;
	logic signed [VALUE_W-1:0] upd_q;
	logic signed [VALUE_W-1:0] upd_sum;
	logic [FRAC_W-1:0] alpha;
	logic [FRAC_W-1:0] gamma;
	logic [FRAC_W-1:0] mul_f;
	logic signed [VALUE_W-1:0] mul_v;
	logic signed [VALUE_W:0] mul_r;
	logic [VALUE_W-1:0] mag;
	logic [VALUE_W+FRAC_W-1:0] mag_prod;
	logic [VALUE_W+FRAC_W-16:0] rnd;
	logic better;
	logic [ACTION_W+16:0] tie_prod;
	logic [ACTION_W-1:0] tie_sel;
	logic res_load;
	result_t res_q;
	logic out_valid_q;

	assign alpha = (learning_rate > ONE_Q16) ? ONE_Q16 : learning_rate;
	assign gamma = (discount > ONE_Q16) ? ONE_Q16 : discount;
	assign cmd_ready = (state_q == S_IDLE);

	// Shared rounding multiplier: round(|v| * f / 65536) with sign restored.
	assign mag = mul_v[VALUE_W-1] ? VALUE_W'(-mul_v) : mul_v;
	assign mag_prod = mag * mul_f;
	assign rnd = (VALUE_W+FRAC_W-15)'((mag_prod + 49'h8000) >> 16);
	assign mul_r = mul_v[VALUE_W-1] ? -$signed({1'b0, rnd[VALUE_W-1:0]})
		: $signed({1'b0, rnd[VALUE_W-1:0]});

	always_comb begin
		mul_v = best_q;
		mul_f = gamma;
		case (state_q)
			S_MUL1: begin mul_v = best_q; mul_f = gamma; end
			S_MUL2: begin mul_v = old_q; mul_f = ONE_Q16 - alpha; end
			S_MUL3: begin mul_v = target_q; mul_f = alpha; end
			default: begin mul_v = best_q; mul_f = gamma; end
		endcase
	end

	// The new table value, written back in the same cycle it is registered.
	assign upd_sum = sat34(34'(prod_a_q) + 34'(prod_b_q));

	// Memory read address: scan walks the actions, train fetches the old value.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = {cmd_q.scan_state, scan_cnt_q[ACTION_W-1:0]};
		case (state_q)
			S_SCAN: rd_en = (scan_cnt_q < (ACTION_W+1)'(NUM_ACTIONS));
			S_TIE: begin rd_en = (cmd_q.op == OP_TRAIN); rd_addr = cmd_q.entry; end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= q_mem[rd_addr];
		if (state_q == S_IDLE && cmd_valid && cmd.op == OP_LOAD)
			q_mem[cmd.entry] <= cmd.table_value;
		else if (state_q == S_SUM)
			q_mem[cmd_q.entry] <= upd_sum;
	end

	assign better = minimize_mode ? (rd_data_q < best_q) : (rd_data_q > best_q);
	assign tie_prod = cmd_q.pick_draw * tie_count_q;
	assign tie_pos = tie_prod[ACTION_W+15:16];

	// Pick the set bit of the tie mask at position tie_pos.
	always_comb begin
		logic [ACTION_W:0] seen;
		seen = '0;
		tie_sel = '0;
		for (int i = NUM_ACTIONS - 1; i >= 0; i--) begin
			if (tie_mask_q[i]) begin
				if ((seen + 1'b1) == (tie_count_q - (ACTION_W+1)'(tie_pos))) tie_sel = ACTION_W'(i);
				seen = seen + 1'b1;
			end
		end
	end

	// A finished result moves to the output register once that register is free.
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// Sequencer for one command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			scan_cnt_q <= '0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						scan_cnt_q <= '0;
						cur_act_q <= '0;
						best_q <= '0;
						err_q <= '0;
						upd_q <= '0;
						chosen_q <= '0;
						case (cmd.op)
							OP_LOAD: begin upd_q <= cmd.table_value; state_q <= S_DONE; end
							OP_SELECT, OP_TRAIN: state_q <= S_SCAN;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (scan_cnt_q != '0) begin
						cur_act_q <= cur_act_q + 1'b1;
						if (cur_act_q == '0 || better) begin
							best_q <= rd_data_q;
							tie_mask_q <= NUM_ACTIONS'(1) << cur_act_q;
							tie_count_q <= (ACTION_W+1)'(1);
						end else if (rd_data_q == best_q) begin
							tie_mask_q[cur_act_q] <= 1'b1;
							tie_count_q <= tie_count_q + 1'b1;
						end
					end
					if (scan_cnt_q == (ACTION_W+1)'(NUM_ACTIONS)) state_q <= S_TIE;
				end
				S_TIE: begin
					if (cmd_q.op == OP_SELECT) begin
						chosen_q <= cmd_q.explore ? cmd_q.pick_draw[15:16-ACTION_W] : tie_sel;
						state_q <= S_DONE;
					end else begin
						state_q <= S_OLD;
					end
				end
				S_OLD: begin
					old_q <= rd_data_q;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					target_q <= cmd_q.is_terminal ? cmd_q.reward
						: sat34(34'(mul_r) + 34'(cmd_q.reward));
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					err_q <= sat34(34'(target_q) - 34'(old_q));
					prod_a_q <= mul_r[VALUE_W-1:0];
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					prod_b_q <= mul_r[VALUE_W-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					upd_q <= upd_sum;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_load) begin
						res_q.chosen_action <= chosen_q;
						res_q.best_value <= best_q;
						res_q.bellman_error <= err_q;
						res_q.updated_value <= upd_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.chosen_action = res_q.chosen_action;
	assign out_ch.best_value = res_q.best_value;
	assign out_ch.bellman_error = res_q.bellman_error;
	assign out_ch.updated_value = res_q.updated_value;

endmodule

### hw/rtl/tabular_q_learning_engine.sv
// Top level of the tabular Q-learning engine.
// Depends on tql_pkg, tql_if, tql_front, tql_queue and tql_back.
//
// Usage:
//  - in_ch carries one operation per transaction: load, select or train.
//  - out_ch returns exactly one result transaction per input transaction,
//    in order.
//  - cfg_ch writes the five control registers by index; write only when idle.
// Processing:
//  - A load goes from acceptance straight to the finished-result state.
//  - A select is bound by the scan of the table memory's single read port,
//    one action per cycle.
//  - A train does the scan, then three passes through the shared multiplier
//    and write-back.
// Reset and stalls:
//  - Reset restores the register defaults. The table content is undefined
//    until loaded.
//  - When out_ch stalls, the back end holds its finished result while the
//    two-entry queue keeps taking input transactions until it is full.
module tabular_q_learning_engine import tql_pkg::*; (
	input logic clk,
	input logic arst_n,
	tql_in_if.sink in_ch,
	tql_out_if.source out_ch,
	tql_cfg_if.sink cfg_ch
);

	logic [FRAC_W-1:0] learning_rate_q;
	logic [FRAC_W-1:0] discount_q;
	logic [FRAC_W-1:0] explore_rate_q;
	logic minimize_mode_q;
	logic training_on_q;
	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	assign cfg_ch.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learning_rate_q <= ONE_Q16;
			discount_q <= ONE_Q16;
			explore_rate_q <= '0;
			minimize_mode_q <= 1'b1;
			training_on_q <= 1'b1;
		end else if (cfg_ch.valid) begin
			case (reg_index_t'(cfg_ch.index))
				REG_LEARNING_RATE: learning_rate_q <= cfg_ch.data[FRAC_W-1:0];
				REG_DISCOUNT: discount_q <= cfg_ch.data[FRAC_W-1:0];
				REG_EXPLORE_RATE: explore_rate_q <= cfg_ch.data[FRAC_W-1:0];
				REG_MINIMIZE_MODE: minimize_mode_q <= cfg_ch.data[0];
				REG_TRAINING_ON: training_on_q <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

	tql_front u_front (
		.in_ch(in_ch),
		.explore_rate(explore_rate_q), .training_on(training_on_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	tql_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	tql_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.learning_rate(learning_rate_q), .discount(discount_q),
		.minimize_mode(minimize_mode_q), .out_ch(out_ch)
	);

endmodule
